// ===== rtl/core/vib_pkg.sv =====
// Shared constants, types and the sine table for the vibrato delay line.
package vib_pkg;

  localparam int BUFFER_DEPTH = 2048;
  localparam int BUF_AW = $clog2(BUFFER_DEPTH);
  localparam int SAMPLE_WIDTH = 16;
  localparam int SINE_DEPTH = 1024;
  localparam int SINE_AW = $clog2(SINE_DEPTH);
  localparam int SINE_W = 16;
  localparam int DELAY_W = 11;
  localparam int DEPTH_W = 11;
  localparam int STEP_W = 32;
  localparam int CFG_W = 32;
  localparam int CFG_IDX_W = 2;
  localparam int PROD_W = DEPTH_W + 1 + SINE_W;
  localparam int CMP_W = (BUF_AW + 2 > 14) ? BUF_AW + 2 : 14;

  localparam logic [CFG_IDX_W-1:0] REG_BASE_DELAY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MOD_DEPTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP = 2'd2;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] ONE_Q30 = 64'd1073741824;

  // Reciprocals of the divisors between successive Taylor series terms, scaled by 2^64 and rounded up.
  localparam logic [127:0] RECIP_SCALE = 128'd1 << 64;
  localparam logic [127:0] TAYLOR_RCP_1 = (RECIP_SCALE + 128'd5) / 128'd6;
  localparam logic [127:0] TAYLOR_RCP_2 = (RECIP_SCALE + 128'd19) / 128'd20;
  localparam logic [127:0] TAYLOR_RCP_3 = (RECIP_SCALE + 128'd41) / 128'd42;
  localparam logic [127:0] TAYLOR_RCP_4 = (RECIP_SCALE + 128'd71) / 128'd72;
  localparam logic [127:0] TAYLOR_RCP_5 = (RECIP_SCALE + 128'd109) / 128'd110;
  localparam logic [127:0] TAYLOR_RCP_6 = (RECIP_SCALE + 128'd155) / 128'd156;

  typedef logic signed [SINE_W-1:0] sine_rom_t [SINE_DEPTH];

  typedef struct packed {
    logic take;
    logic en_a;
    logic en_b;
    logic en_c;
    logic b_valid;
  } vib_flow_t;

  function automatic sine_rom_t build_sine_rom();
    sine_rom_t rom;
    logic [63:0] p;
    logic [63:0] r;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] num;
    logic [127:0] rcp;
    logic [63:0] v;
    logic [1:0] quad;
    for (int k = 0; k < SINE_DEPTH; k++) begin
      p = 64'(k) << (32 - SINE_AW);
      quad = p[31:30];
      r = p & (ONE_Q30 - 64'd1);
      if (quad[0]) begin
        r = ONE_Q30 - r;
      end
      x = (r * HALF_PI_Q30) >> 30;
      x2 = (x * x) >> 30;
      term = x;
      sum = x;
      for (int n = 1; n <= 6; n++) begin
        case (n)
          1: rcp = TAYLOR_RCP_1;
          2: rcp = TAYLOR_RCP_2;
          3: rcp = TAYLOR_RCP_3;
          4: rcp = TAYLOR_RCP_4;
          5: rcp = TAYLOR_RCP_5;
          default: rcp = TAYLOR_RCP_6;
        endcase
        num = (term * x2) >> 30;
        term = 64'((128'(num) * rcp) >> 64);
        if (n[0]) begin
          sum = sum - term;
        end else begin
          sum = sum + term;
        end
      end
      v = (sum * 64'd32767 + (ONE_Q30 >> 1)) >> 30;
      if (v > 64'd32767) begin
        v = 64'd32767;
      end
      if (quad[1]) begin
        rom[k] = -$signed(v[SINE_W-1:0]);
      end else begin
        rom[k] = $signed(v[SINE_W-1:0]);
      end
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

// ===== rtl/core/vib_lfo.sv =====
// Sine oscillator: phase accumulator, registered sine table read and depth multiply.
module vib_lfo import vib_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  vib_flow_t                flow,
  input  logic [STEP_W-1:0]        phase_step,
  input  logic [DEPTH_W-1:0]       mod_depth,
  output logic signed [PROD_W-1:0] swing_prod
);

  logic [31:0] lfo_phase;
  logic signed [SINE_W-1:0] a_sine;

  always_ff @(posedge clk) begin
    if (rst) begin
      lfo_phase <= '0;
    end else if (flow.take) begin
      lfo_phase <= lfo_phase + phase_step;
    end
  end

  always_ff @(posedge clk) begin
    if (flow.en_a) begin
      a_sine <= SINE_ROM[lfo_phase[31 -: SINE_AW]];
    end
  end

  always_ff @(posedge clk) begin
    if (flow.en_b) begin
      swing_prod <= PROD_W'($signed({1'b0, mod_depth})) * PROD_W'(a_sine);
    end
  end

endmodule

// ===== rtl/core/vib_tap.sv =====
// Ring buffer memory with write pointer and the modulated read tap.
module vib_tap import vib_pkg::*; (
  input  logic                           clk,
  input  logic                           rst,
  input  vib_flow_t                      flow,
  input  logic [DELAY_W-1:0]             base_delay,
  input  logic signed [PROD_W-1:0]       swing_prod,
  input  logic signed [SAMPLE_WIDTH-1:0] wr_sample,
  output logic signed [SAMPLE_WIDTH-1:0] tap_sample
);

  logic [SAMPLE_WIDTH-1:0] mem [BUFFER_DEPTH];
  logic [BUF_AW-1:0] widx;
  logic wrapped;
  logic [SAMPLE_WIDTH-1:0] rd_q;
  logic rd_ok;
  logic rd_ok_next;
  logic wr;
  logic signed [PROD_W-1:0] rounded;
  logic signed [CMP_W-1:0] delay_raw;
  logic [BUF_AW-1:0] delay;
  logic [BUF_AW-1:0] raddr;

  assign wr = flow.en_c && flow.b_valid;

  always_comb begin
    rounded = (swing_prod + PROD_W'(16384)) >>> 15;
    delay_raw = $signed(CMP_W'({1'b0, base_delay})) + CMP_W'(rounded);
    if (delay_raw < 0) begin
      delay = '0;
    end else if (delay_raw > $signed(CMP_W'(BUFFER_DEPTH - 1))) begin
      delay = BUF_AW'(BUFFER_DEPTH - 1);
    end else begin
      delay = delay_raw[BUF_AW-1:0];
    end
    raddr = widx - delay;
    rd_ok_next = wrapped || (raddr < widx);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      widx <= '0;
      wrapped <= 1'b0;
    end else if (wr) begin
      widx <= widx + 1'b1;
      if (widx == BUF_AW'(BUFFER_DEPTH - 1)) begin
        wrapped <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[widx] <= wr_sample;
    end
    if (flow.en_c) begin
      rd_q <= mem[raddr];
      rd_ok <= rd_ok_next;
    end
  end

  assign tap_sample = rd_ok ? $signed(rd_q) : '0;

endmodule

// ===== rtl/core/lfo_modulated_delay_vibrato.sv =====
// Top level of the vibrato delay line: handshakes, configuration and pipeline control.
// A request passes through registers a, b and c and then the output register; a stall can hold it at any of them.
// Throughput: one request per cycle unless stalled, set by one ring buffer read and write per cycle.
// Reset clears the registers, write pointer, LFO phase and pipeline valid bits.
// The ring buffer is not swept; entries not yet written since reset read as zero.
module lfo_modulated_delay_vibrato import vib_pkg::*; (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [CFG_IDX_W-1:0]           cfg_index,
  input  logic [CFG_W-1:0]               cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_in,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [SAMPLE_WIDTH-1:0] sample_out
);

  logic [DELAY_W-1:0] base_delay;
  logic [DEPTH_W-1:0] mod_depth;
  logic [STEP_W-1:0] phase_step;
  logic a_valid;
  logic b_valid;
  logic c_valid;
  logic signed [SAMPLE_WIDTH-1:0] a_sample;
  logic signed [SAMPLE_WIDTH-1:0] b_sample;
  logic signed [PROD_W-1:0] swing_prod;
  logic signed [SAMPLE_WIDTH-1:0] tap_sample;
  logic en_d;
  vib_flow_t flow;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_delay <= '0;
      mod_depth <= '0;
      phase_step <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BASE_DELAY: base_delay <= cfg_data[DELAY_W-1:0];
        REG_MOD_DEPTH: mod_depth <= cfg_data[DEPTH_W-1:0];
        REG_PHASE_STEP: phase_step <= cfg_data[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    en_d = !out_valid || !out_stall;
    flow.en_c = !c_valid || en_d;
    flow.en_b = !b_valid || flow.en_c;
    flow.en_a = !a_valid || flow.en_b;
    flow.b_valid = b_valid;
    flow.take = in_valid && flow.en_a;
    in_stall = !flow.en_a;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (flow.en_a) begin
        a_valid <= in_valid;
      end
      if (flow.en_b) begin
        b_valid <= a_valid;
      end
      if (flow.en_c) begin
        c_valid <= b_valid;
      end
      if (en_d) begin
        out_valid <= c_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (flow.en_a) begin
      a_sample <= sample_in;
    end
    if (flow.en_b) begin
      b_sample <= a_sample;
    end
    if (en_d) begin
      sample_out <= tap_sample;
    end
  end

  vib_lfo u_lfo (
    .clk        (clk),
    .rst        (rst),
    .flow       (flow),
    .phase_step (phase_step),
    .mod_depth  (mod_depth),
    .swing_prod (swing_prod)
  );

  vib_tap u_tap (
    .clk        (clk),
    .rst        (rst),
    .flow       (flow),
    .base_delay (base_delay),
    .swing_prod (swing_prod),
    .wr_sample  (b_sample),
    .tap_sample (tap_sample)
  );

  // The input is held back only when the first stage is occupied.
  assert property (@(posedge clk) disable iff (rst) in_stall |-> a_valid)
    else $error("input stalled with an empty first stage");

  // An empty output register lets every stage advance.
  assert property (@(posedge clk) disable iff (rst) !out_valid |-> !in_stall)
    else $error("input stalled while the output register is empty");

  // An accepted request occupies the first stage on the next cycle.
  assert property (@(posedge clk) disable iff (rst) (in_valid && !in_stall) |=> a_valid)
    else $error("accepted request lost at the first stage");

endmodule

// ===== bench/testbench.sv =====
// Self-checking testbench for the LFO-modulated vibrato delay line, with its own tap predictor.
module testbench import vib_pkg::*; ();

  localparam logic [63:0] Q30_ONE = 64'd1073741824;
  localparam logic [63:0] Q30_HALF_PI = 64'd1686629713;
  localparam int CYCLE_LIMIT = 300000;
  localparam int PHASE_COUNT = 8;
  localparam int PHASE_ITEMS = 173;

  typedef enum logic {ROW_SAMPLE, ROW_REG} row_kind_t;

  typedef struct packed {
    row_kind_t kind;
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_W-1:0] data;
    logic [SAMPLE_WIDTH-1:0] smp;
    logic chk;
    logic [SAMPLE_WIDTH-1:0] want;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_BASE_DELAY;
  logic [CFG_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [SAMPLE_WIDTH-1:0] sample_in = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [SAMPLE_WIDTH-1:0] sample_out;

  lfo_modulated_delay_vibrato u_top (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .sample_in(sample_in),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .sample_out(sample_out)
  );

  // Predictor state.
  logic signed [SINE_W-1:0] sine_q15 [SINE_DEPTH];
  logic [SAMPLE_WIDTH-1:0] ring [BUFFER_DEPTH];
  logic [BUF_AW-1:0] wr_ptr;
  logic [31:0] lfo_acc;
  logic [DELAY_W-1:0] base_reg;
  logic [DEPTH_W-1:0] depth_reg;
  logic [STEP_W-1:0] step_reg;

  logic [SAMPLE_WIDTH-1:0] tap_queue [$];
  logic [SAMPLE_WIDTH-1:0] want_tap;
  int fail_count = 0;
  int n_sent = 0;
  int n_checked = 0;
  int n_settings = 0;
  int n_clamped = 0;
  int cycles = 0;
  int stall_left = 0;
  logic quiet = 1'b0;

  row_t directed_rows [25] = '{
    '{ROW_SAMPLE, REG_BASE_DELAY, 32'h0, 16'h7FFF, 1'b1, 16'h0000},
    '{ROW_SAMPLE, REG_BASE_DELAY, 32'h0, 16'h8000, 1'b1, 16'h0000},
    '{ROW_SAMPLE, REG_BASE_DELAY, 32'h0, 16'h0000, 1'b1, 16'h0000},
    '{ROW_SAMPLE, REG_BASE_DELAY, 32'h0, 16'hFFFF, 1'b1, 16'h0000},
    '{ROW_REG, REG_BASE_DELAY, 32'hFFFF_F801, 16'h0, 1'b0, 16'h0},
    '{ROW_SAMPLE, REG_BASE_DELAY, 32'h0, 16'h0001, 1'b1, 16'hFFFF},
    '{ROW_SAMPLE, REG_BASE_DELAY, 32'h0, 16'h5555, 1'b1, 16'h0001},
    '{ROW_SAMPLE, REG_BASE_DELAY, 32'h0, 16'hAAAA, 1'b1, 16'h5555},
    '{ROW_REG, REG_BASE_DELAY, 32'h0000_07FF, 16'h0, 1'b0, 16'h0},
    '{ROW_SAMPLE, REG_BASE_DELAY, 32'h0, 16'h1234, 1'b1, 16'h0000},
    '{ROW_REG, REG_BASE_DELAY, 32'h0, 16'h0, 1'b0, 16'h0},
    '{ROW_REG, REG_MOD_DEPTH, 32'hAAAA_AFFF, 16'h0, 1'b0, 16'h0},
    '{ROW_REG, REG_PHASE_STEP, 32'h4000_0000, 16'h0, 1'b0, 16'h0},
    '{ROW_SAMPLE, REG_BASE_DELAY, 32'h0, 16'h0F0F, 1'b0, 16'h0},
    '{ROW_SAMPLE, REG_BASE_DELAY, 32'h0, 16'hF0F0, 1'b0, 16'h0},
    '{ROW_SAMPLE, REG_BASE_DELAY, 32'h0, 16'h7FFE, 1'b0, 16'h0},
    '{ROW_SAMPLE, REG_BASE_DELAY, 32'h0, 16'h8001, 1'b0, 16'h0},
    '{ROW_SAMPLE, REG_BASE_DELAY, 32'h0, 16'h00FF, 1'b0, 16'h0},
    '{ROW_REG, REG_PHASE_STEP, 32'hFFFF_FFFF, 16'h0, 1'b0, 16'h0},
    '{ROW_REG, REG_BASE_DELAY, 32'h0000_0400, 16'h0, 1'b0, 16'h0},
    '{ROW_REG, REG_MOD_DEPTH, 32'h0000_0400, 16'h0, 1'b0, 16'h0},
    '{ROW_SAMPLE, REG_BASE_DELAY, 32'h0, 16'hFF00, 1'b0, 16'h0},
    '{ROW_SAMPLE, REG_BASE_DELAY, 32'h0, 16'h3C3C, 1'b0, 16'h0},
    '{ROW_SAMPLE, REG_BASE_DELAY, 32'h0, 16'hC3C3, 1'b0, 16'h0},
    '{ROW_SAMPLE, REG_BASE_DELAY, 32'h0, 16'h8000, 1'b0, 16'h0}
  };

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic void fill_sine();
    bit [63:0] p, r, x, x2, term, acc, v;
    for (int k = 0; k < SINE_DEPTH; k++) begin
      p = (64'(k) << 32) / SINE_DEPTH;
      r = p & (Q30_ONE - 64'd1);
      if (p[30]) begin
        r = Q30_ONE - r;
      end
      x = (r * Q30_HALF_PI) >> 30;
      x2 = (x * x) >> 30;
      term = x;
      acc = x;
      for (int n = 1; n <= 6; n++) begin
        term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
        if (n % 2 == 1) begin
          acc = acc - term;
        end else begin
          acc = acc + term;
        end
      end
      v = (acc * 64'd32767 + (Q30_ONE >> 1)) >> 30;
      if (v > 64'd32767) begin
        v = 64'd32767;
      end
      sine_q15[k] = p[31] ? -16'(v) : 16'(v);
    end
  endfunction

  // Returns the tap sample for one request and advances the LFO and the ring.
  function automatic logic [SAMPLE_WIDTH-1:0] predict_tap(input logic [SAMPLE_WIDTH-1:0] smp);
    logic signed [SINE_W-1:0] s;
    longint swing;
    longint dly;
    logic [BUF_AW-1:0] rd;
    s = sine_q15[lfo_acc[31 -: SINE_AW]];
    lfo_acc = lfo_acc + step_reg;
    swing = (longint'(depth_reg) * longint'(s) + 64'sd16384) >>> 15;
    dly = longint'(base_reg) + swing;
    if (dly < 0) begin
      dly = 0;
      n_clamped++;
    end else if (dly > BUFFER_DEPTH - 1) begin
      dly = BUFFER_DEPTH - 1;
      n_clamped++;
    end
    rd = wr_ptr - BUF_AW'(dly);
    predict_tap = ring[rd];
    ring[wr_ptr] = smp;
    wr_ptr = wr_ptr + 1'b1;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_BASE_DELAY: base_reg = data[DELAY_W-1:0];
      REG_MOD_DEPTH: depth_reg = data[DEPTH_W-1:0];
      REG_PHASE_STEP: step_reg = data[STEP_W-1:0];
      default: ;
    endcase
  endtask

  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (tap_queue.size() != 0) begin
      @(posedge clk);
    end
    repeat (6) @(posedge clk);
  endtask

  task automatic push_sample(input logic [SAMPLE_WIDTH-1:0] smp, input logic chk,
                             input logic [SAMPLE_WIDTH-1:0] want);
    int gap;
    logic [SAMPLE_WIDTH-1:0] got;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 8);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end else begin
      @(negedge clk);
    end
    in_valid <= 1'b1;
    sample_in <= smp;
    do begin
      @(posedge clk);
    end while (!(in_valid && !in_stall));
    got = predict_tap(smp);
    tap_queue.push_back(chk ? want : got);
    n_sent++;
  endtask

  task automatic load_setting(input logic [DELAY_W-1:0] b, input logic [DEPTH_W-1:0] d,
                              input logic [STEP_W-1:0] st);
    settle();
    write_reg(REG_BASE_DELAY, ($urandom & ~32'h7FF) | 32'(b));
    write_reg(REG_MOD_DEPTH, ($urandom & ~32'h7FF) | 32'(d));
    write_reg(REG_PHASE_STEP, st);
    n_settings++;
  endtask

  always @(negedge clk) begin
    if (quiet) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 7);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (tap_queue.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) begin
          $display("Unexpected sample_out %h with no request pending.", sample_out);
        end
      end else begin
        want_tap = tap_queue.pop_front();
        n_checked++;
        if (sample_out !== want_tap) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("sample_out mismatch at result %0d: expected %h, got %h.",
                     n_checked, want_tap, sample_out);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results pending.", cycles, tap_queue.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    logic [DELAY_W-1:0] b;
    logic [DEPTH_W-1:0] d;
    logic [STEP_W-1:0] st;
    fill_sine();
    for (int i = 0; i < BUFFER_DEPTH; i++) begin
      ring[i] = '0;
    end
    wr_ptr = '0;
    lfo_acc = '0;
    base_reg = '0;
    depth_reg = '0;
    step_reg = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_REG) begin
        settle();
        write_reg(directed_rows[i].idx, directed_rows[i].data);
      end else begin
        push_sample(directed_rows[i].smp, directed_rows[i].chk, directed_rows[i].want);
      end
    end

    // The zero-delay phase runs last, with idling switched off on both sides.
    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      b = DELAY_W'($urandom);
      d = DEPTH_W'($urandom);
      st = $urandom;
      case (ph)
        0: begin
          b = DELAY_W'($urandom_range(0, 64));
          d = DEPTH_W'($urandom_range(0, 64));
        end
        1: b = '0;
        2: begin
          b = '1;
          d = '1;
          st = '1;
        end
        3: st = $urandom_range(0, 1 << 24);
        5: begin
          b = '1;
          d = '0;
          st = '0;
        end
        7: begin
          b = '0;
          d = '0;
          quiet = 1'b1;
        end
        default: ;
      endcase
      load_setting(b, d, st);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (ph == 4 && k == PHASE_ITEMS / 2) begin
          settle();
        end
        push_sample(SAMPLE_WIDTH'($urandom), 1'b0, '0);
      end
    end

    settle();
    repeat (10) @(posedge clk);
    if (tap_queue.size() != 0) begin
      fail_count++;
      $display("%0d expected results never arrived.", tap_queue.size());
    end
    $display("Sent %0d samples over %0d register settings and checked %0d taps.",
             n_sent, n_settings, n_checked);
    $display("Swept the LFO at slow to full-rate steps; %0d taps hit a clamp limit.",
             n_clamped);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/vib_pkg.sv
rtl/core/vib_lfo.sv
rtl/core/vib_tap.sv
rtl/core/lfo_modulated_delay_vibrato.sv
bench/testbench.sv
